/* rtl/aovc_pkg.sv */
package aovc_pkg;

	// event selector carried in tuser
	localparam logic [1:0] FUNC_QUERY   = 2'd0;
	localparam logic [1:0] FUNC_MONITOR = 2'd1;
	localparam logic [1:0] FUNC_RESET   = 2'd2;

	// attached cable classes
	localparam logic [1:0] CABLE_PPS   = 2'd0;
	localparam logic [1:0] CABLE_NOCHG = 2'd1;

	// controller states
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_PRESET  = 3'd1;
	localparam logic [2:0] ST_MONITOR = 3'd2;
	localparam logic [2:0] ST_HOLD    = 3'd3;
	localparam logic [2:0] ST_ERR     = 3'd4;

	// charger presence
	localparam logic [1:0] CP_NONE  = 2'd0;
	localparam logic [1:0] CP_NOCHG = 2'd1;
	localparam logic [1:0] CP_CHG   = 2'd2;

	// input current limit actions
	localparam logic [1:0] ICL_KEEP    = 2'd0;
	localparam logic [1:0] ICL_SET     = 2'd1;
	localparam logic [1:0] ICL_RELEASE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_AOV_ENABLE      = 3'd0;
	localparam logic [2:0] REG_START_VOLTAGE   = 3'd1;
	localparam logic [2:0] REG_LOW_FREQ        = 3'd2;
	localparam logic [2:0] REG_HIGH_FREQ       = 3'd3;
	localparam logic [2:0] REG_STEP_DELAY      = 3'd4;
	localparam logic [2:0] REG_HOLD_CURRENT    = 3'd5;
	localparam logic [2:0] REG_HOLD_CURR_FULL  = 3'd6;
	localparam logic [2:0] REG_GEAR_CURRENT    = 3'd7;

	// register reset values
	localparam logic        RST_AOV_ENABLE     = 1'b1;
	localparam logic [12:0] RST_START_VOLTAGE  = 13'd5500;
	localparam logic [9:0]  RST_LOW_FREQ       = 10'd131;
	localparam logic [9:0]  RST_HIGH_FREQ      = 10'd147;
	localparam logic [15:0] RST_STEP_DELAY     = 16'd3000;
	localparam logic [11:0] RST_HOLD_CURRENT   = 12'd800;
	localparam logic [11:0] RST_HOLD_CURR_FULL = 12'd100;
	localparam logic [11:0] RST_GEAR_CURRENT   = 12'd0;

	// voltage and timing constants
	localparam logic [14:0] VSTEP_MV        = 15'd500;
	localparam logic [14:0] VMAX_MV         = 15'd7500;
	localparam logic [14:0] VMIN_MV         = 15'd5000;
	localparam logic [9:0]  FULL_PERMILLE   = 10'd970;
	localparam logic [16:0] FIRST_EXTRA_MS  = 17'd1000;
	localparam logic [16:0] RAMP_DELAY_MS   = 17'd500;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_ADDR_W = 5;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  cable_class;
		logic        pdo_power_ok;
		logic [13:0] measured_vout_mv;
		logic        power_hold;
		logic [9:0]  op_freq;
		logic [9:0]  capacity_permille;
	} in_item_t;

	typedef struct packed {
		logic        enabled;
		logic [2:0]  aov_state;
		logic        vout_set;
		logic [13:0] vout_cmd_mv;
		logic [1:0]  icl_action;
		logic [11:0] icl_cmd_ma;
		logic        uno_iout_set;
		logic        delay_set;
		logic [16:0] delay_ms;
		logic        vote_refresh;
	} out_item_t;

	typedef struct packed {
		logic        aov_enable;
		logic [12:0] start_voltage_mv;
		logic [9:0]  low_freq_threshold;
		logic [9:0]  high_freq_threshold;
		logic [15:0] step_delay_ms;
		logic [11:0] hold_current_ma;
		logic [11:0] hold_current_full_ma;
		logic [11:0] gear_current_ma;
	} cfg_t;

	typedef struct packed {
		logic [2:0] state;
		logic [1:0] cp;
		logic [1:0] prev_cp;
	} ctrl_t;

endpackage

/* rtl/wireless_tx_adaptive_vout_control_core.sv */
// Adaptive output-voltage controller. Each input beat is one event chosen by s_tuser
// (query, monitor step, reset) and yields exactly one result beat. A beat lands in an
// input register, the step logic evaluates it combinationally against the controller
// state, and the result is held in an output register; throughput is one beat per clock
// while m_tready keeps the output register drained, else s_tready drops. The controller state
// updates as each beat passes into the output register, so consecutive beats see each
// other's effect in order. Registers sit on the APB port at byte addresses 4*i; write
// them only while no beat is in flight.
module wireless_tx_adaptive_vout_control_core
	import aovc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] cable_class, [2] pdo_power_ok, [16:3] measured_vout_mv, [17] power_hold,
	// [27:18] op_freq, [37:28] capacity_permille
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] func
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] enabled, [3:1] aov_state, [4] vout_set, [18:5] vout_cmd_mv, [20:19] icl_action,
	// [32:21] icl_cmd_ma, [33] uno_iout_set, [34] delay_set, [51:35] delay_ms,
	// [52] vote_refresh
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t      cfg;
	in_item_t  item_in;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_q;
	logic      res_valid_q;
	ctrl_t     ctrl_q;
	ctrl_t     ctrl_nxt;
	logic      adv;

	assign pready = 1'b1;

	aovc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign item_in.func              = s_tuser;
	assign item_in.cable_class       = s_tdata[1:0];
	assign item_in.pdo_power_ok      = s_tdata[2];
	assign item_in.measured_vout_mv  = s_tdata[16:3];
	assign item_in.power_hold        = s_tdata[17];
	assign item_in.op_freq           = s_tdata[27:18];
	assign item_in.capacity_permille = s_tdata[37:28];

	// input beat moves on when the result register is free or being drained
	assign adv      = valid_s1 & (~res_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	aovc_step u_step (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (ctrl_q),
		.nxt  (ctrl_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '{state: ST_NONE, cp: CP_NONE, prev_cp: CP_NONE};
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				ctrl_q <= ctrl_nxt;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {3'd0, res_q.vote_refresh, res_q.delay_ms, res_q.delay_set,
		res_q.uno_iout_set, res_q.icl_cmd_ma, res_q.icl_action, res_q.vout_cmd_mv,
		res_q.vout_set, res_q.aov_state, res_q.enabled};

	a_no_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.state != ST_ERR)
		else $error("controller reached the error state");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctrl_q))
		else $error("controller state changed without a beat advancing");

	a_vcmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.vout_set |-> res_q.vout_cmd_mv == '0)
		else $error("voltage command without vout_set");

	a_icl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.icl_action != ICL_SET |-> res_q.icl_cmd_ma == '0)
		else $error("current limit value without a set action");

	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_q.aov_state == ctrl_q.state)
		else $error("reported state differs from controller state");

endmodule

/* rtl/aovc_regs.sv */
module aovc_regs
	import aovc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.aov_enable           <= RST_AOV_ENABLE;
			cfg_q.start_voltage_mv     <= RST_START_VOLTAGE;
			cfg_q.low_freq_threshold   <= RST_LOW_FREQ;
			cfg_q.high_freq_threshold  <= RST_HIGH_FREQ;
			cfg_q.step_delay_ms        <= RST_STEP_DELAY;
			cfg_q.hold_current_ma      <= RST_HOLD_CURRENT;
			cfg_q.hold_current_full_ma <= RST_HOLD_CURR_FULL;
			cfg_q.gear_current_ma      <= RST_GEAR_CURRENT;
		end else if (wr_en) begin
			unique case (idx)
				REG_AOV_ENABLE:     cfg_q.aov_enable           <= pwdata[0];
				REG_START_VOLTAGE:  cfg_q.start_voltage_mv     <= pwdata[12:0];
				REG_LOW_FREQ:       cfg_q.low_freq_threshold   <= pwdata[9:0];
				REG_HIGH_FREQ:      cfg_q.high_freq_threshold  <= pwdata[9:0];
				REG_STEP_DELAY:     cfg_q.step_delay_ms        <= pwdata[15:0];
				REG_HOLD_CURRENT:   cfg_q.hold_current_ma      <= pwdata[11:0];
				REG_HOLD_CURR_FULL: cfg_q.hold_current_full_ma <= pwdata[11:0];
				REG_GEAR_CURRENT:   cfg_q.gear_current_ma      <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_AOV_ENABLE:     prdata = {31'd0, cfg_q.aov_enable};
			REG_START_VOLTAGE:  prdata = {19'd0, cfg_q.start_voltage_mv};
			REG_LOW_FREQ:       prdata = {22'd0, cfg_q.low_freq_threshold};
			REG_HIGH_FREQ:      prdata = {22'd0, cfg_q.high_freq_threshold};
			REG_STEP_DELAY:     prdata = {16'd0, cfg_q.step_delay_ms};
			REG_HOLD_CURRENT:   prdata = {20'd0, cfg_q.hold_current_ma};
			REG_HOLD_CURR_FULL: prdata = {20'd0, cfg_q.hold_current_full_ma};
			REG_GEAR_CURRENT:   prdata = {20'd0, cfg_q.gear_current_ma};
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/aovc_step.sv */
module aovc_step
	import aovc_pkg::*;
(
	input  in_item_t  item,
	input  cfg_t      cfg,
	input  ctrl_t     cur,
	output ctrl_t     nxt,
	output out_item_t res
);

	logic [2:0]  st;
	logic [1:0]  pcp;
	logic        to_mon;
	logic [14:0] vout_w;
	logic [14:0] nv;
	logic [14:0] start_w;
	logic [11:0] hold_lim;

	assign start_w  = {2'b00, cfg.start_voltage_mv};
	assign hold_lim = (item.capacity_permille >= FULL_PERMILLE) ?
		cfg.hold_current_full_ma : cfg.hold_current_ma;

	always_comb begin
		nxt    = cur;
		res    = '0;
		st     = cur.state;
		pcp    = cur.prev_cp;
		to_mon = 1'b0;
		vout_w = {1'b0, item.measured_vout_mv};
		nv     = vout_w;

		unique case (item.func)
			FUNC_QUERY: begin
				if (cfg.aov_enable && cur.state != ST_ERR) begin
					if (item.cable_class == CABLE_PPS) begin
						// pps without usable range only blocks before the controller runs
						if (!(cur.state == ST_NONE && !item.pdo_power_ok)) begin
							nxt.cp      = CP_CHG;
							res.enabled = 1'b1;
						end
					end else if (item.cable_class == CABLE_NOCHG) begin
						nxt.cp      = CP_NOCHG;
						res.enabled = 1'b1;
					end else if (cur.state != ST_NONE) begin
						nxt.state      = ST_NONE;
						nxt.cp         = CP_NONE;
						res.icl_action = ICL_RELEASE;
					end
				end
			end
			FUNC_RESET: begin
				nxt.state      = ST_NONE;
				nxt.cp         = CP_NONE;
				res.icl_action = ICL_RELEASE;
			end
			FUNC_MONITOR: begin
				if (st == ST_NONE) begin
					pcp = CP_NONE;
					st  = ST_PRESET;
				end
				priority if (st == ST_PRESET) begin
					if (vout_w < start_w) begin
						if (cur.state == ST_NONE) begin
							// first step only waits
							res.delay_set = 1'b1;
							res.delay_ms  = {1'b0, cfg.step_delay_ms} + FIRST_EXTRA_MS;
						end else begin
							vout_w          = vout_w + VSTEP_MV;
							res.vout_set    = 1'b1;
							res.vout_cmd_mv = vout_w[13:0];
							res.delay_set   = 1'b1;
							res.delay_ms    = (vout_w == start_w) ?
								{cfg.step_delay_ms, 1'b0} : RAMP_DELAY_MS;
						end
					end else begin
						st     = ST_MONITOR;
						to_mon = 1'b1;
					end
				end else if (st == ST_MONITOR) begin
					to_mon = 1'b1;
				end else if (st == ST_HOLD) begin
					if (!item.power_hold) begin
						res.vout_set    = 1'b1;
						res.vout_cmd_mv = start_w[13:0] + VSTEP_MV[13:0];
						if (cfg.gear_current_ma != '0) begin
							res.icl_action = ICL_SET;
							res.icl_cmd_ma = cfg.gear_current_ma;
						end else begin
							res.icl_action = ICL_RELEASE;
						end
						res.delay_set = 1'b1;
						res.delay_ms  = {1'b0, cfg.step_delay_ms};
						st            = ST_MONITOR;
					end else begin
						res.icl_action = ICL_SET;
						res.icl_cmd_ma = hold_lim;
					end
				end

				if (to_mon) begin
					if (item.power_hold) begin
						res.icl_action   = ICL_SET;
						res.icl_cmd_ma   = hold_lim;
						res.vout_set     = 1'b1;
						res.vout_cmd_mv  = VMIN_MV[13:0];
						res.uno_iout_set = 1'b1;
						st               = ST_HOLD;
					end else begin
						priority if (item.op_freq <= cfg.low_freq_threshold && vout_w < VMAX_MV)
							nv = vout_w + VSTEP_MV;
						else if (item.op_freq >= cfg.high_freq_threshold && vout_w > VMIN_MV)
							nv = vout_w - VSTEP_MV;
						else
							nv = vout_w;
						// a charger that just replaced a no-charge cable forces a new vote
						if (nv != vout_w || (pcp == CP_NOCHG && cur.cp == CP_CHG)) begin
							res.vout_set    = 1'b1;
							res.vout_cmd_mv = nv[13:0];
							res.delay_set   = 1'b1;
							res.delay_ms    = {1'b0, cfg.step_delay_ms};
						end else begin
							res.vote_refresh = 1'b1;
						end
					end
				end
				nxt.state   = st;
				nxt.prev_cp = cur.cp;
			end
			default: ;
		endcase

		res.aov_state = nxt.state;
	end

endmodule

/* verif/wireless_tx_adaptive_vout_control_core_test.sv */
module wireless_tx_adaptive_vout_control_core_test;
	import aovc_pkg::*;

	localparam logic [1:0] FUNC_NOOP     = 2'd3;
	localparam logic [1:0] CABLE_WIRED   = 2'd2;
	localparam logic [1:0] CABLE_UNKNOWN = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BEATS_PER_PHASE = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// controller model: register copy and state
	cfg_t cfg_now = '{RST_AOV_ENABLE, RST_START_VOLTAGE, RST_LOW_FREQ, RST_HIGH_FREQ,
		RST_STEP_DELAY, RST_HOLD_CURRENT, RST_HOLD_CURR_FULL, RST_GEAR_CURRENT};
	ctrl_t ctl = '0;

	in_item_t  event_queue[$];
	out_item_t expected_results[$];
	int        n_queued = 0;
	int        n_driven = 0;
	int        n_in_acc = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        idle_cycles = 0;
	bit        quiet_run = 1'b0;
	bit        failed = 1'b0;
	bit        active;
	in_item_t  seen;
	in_item_t  ev;
	out_item_t want;
	out_item_t got;

	wireless_tx_adaptive_vout_control_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [11:0] hold_limit(logic [9:0] cap);
		return (cap >= FULL_PERMILLE) ? cfg_now.hold_current_full_ma : cfg_now.hold_current_ma;
	endfunction

	function automatic out_item_t step_controller(in_item_t e);
		out_item_t r;
		logic [2:0] entry;
		logic go_monitor;
		int unsigned v, nv;
		r = '0;
		v = e.measured_vout_mv;
		case (e.func)
		FUNC_QUERY: begin
			if (cfg_now.aov_enable && ctl.state != ST_ERR) begin
				if (e.cable_class == CABLE_PPS) begin
					// usable-power check only before the controller has started
					if (!(ctl.state == ST_NONE && !e.pdo_power_ok)) begin
						ctl.cp = CP_CHG;
						r.enabled = 1'b1;
					end
				end else if (e.cable_class == CABLE_NOCHG) begin
					ctl.cp = CP_NOCHG;
					r.enabled = 1'b1;
				end else if (ctl.state != ST_NONE) begin
					ctl.state = ST_NONE;
					ctl.cp = CP_NONE;
					r.icl_action = ICL_RELEASE;
				end
			end
		end
		FUNC_RESET: begin
			ctl.state = ST_NONE;
			ctl.cp = CP_NONE;
			r.icl_action = ICL_RELEASE;
		end
		FUNC_MONITOR: begin
			entry = ctl.state;
			go_monitor = 1'b0;
			if (ctl.state == ST_NONE) begin
				ctl.prev_cp = CP_NONE;
				ctl.state = ST_PRESET;
			end
			if (ctl.state == ST_PRESET) begin
				if (v < cfg_now.start_voltage_mv) begin
					r.delay_set = 1'b1;
					if (entry == ST_NONE) begin
						r.delay_ms = cfg_now.step_delay_ms + FIRST_EXTRA_MS;
					end else begin
						v = v + VSTEP_MV;
						r.vout_set = 1'b1;
						r.vout_cmd_mv = 14'(v);
						r.delay_ms = (v == cfg_now.start_voltage_mv) ?
							{cfg_now.step_delay_ms, 1'b0} : RAMP_DELAY_MS;
					end
				end else begin
					ctl.state = ST_MONITOR;
					go_monitor = 1'b1;
				end
			end else if (ctl.state == ST_MONITOR) begin
				go_monitor = 1'b1;
			end else if (ctl.state == ST_HOLD) begin
				if (!e.power_hold) begin
					r.vout_set = 1'b1;
					r.vout_cmd_mv = 14'(cfg_now.start_voltage_mv + VSTEP_MV);
					if (cfg_now.gear_current_ma != '0) begin
						r.icl_action = ICL_SET;
						r.icl_cmd_ma = cfg_now.gear_current_ma;
					end else begin
						r.icl_action = ICL_RELEASE;
					end
					r.delay_set = 1'b1;
					r.delay_ms = {1'b0, cfg_now.step_delay_ms};
					ctl.state = ST_MONITOR;
				end else begin
					r.icl_action = ICL_SET;
					r.icl_cmd_ma = hold_limit(e.capacity_permille);
				end
			end
			if (go_monitor) begin
				if (e.power_hold) begin
					r.icl_action = ICL_SET;
					r.icl_cmd_ma = hold_limit(e.capacity_permille);
					r.vout_set = 1'b1;
					r.vout_cmd_mv = 14'(VMIN_MV);
					r.uno_iout_set = 1'b1;
					ctl.state = ST_HOLD;
				end else begin
					nv = v;
					if (e.op_freq <= cfg_now.low_freq_threshold && v < VMAX_MV)
						nv = v + VSTEP_MV;
					else if (e.op_freq >= cfg_now.high_freq_threshold && v > VMIN_MV)
						nv = v - VSTEP_MV;
					// a cable swap to a real charger forces a fresh vote
					if (nv != v || (ctl.prev_cp == CP_NOCHG && ctl.cp == CP_CHG)) begin
						r.vout_set = 1'b1;
						r.vout_cmd_mv = 14'(nv);
						r.delay_set = 1'b1;
						r.delay_ms = {1'b0, cfg_now.step_delay_ms};
					end else begin
						r.vote_refresh = 1'b1;
					end
				end
			end
			ctl.prev_cp = ctl.cp;
		end
		default: ;
		endcase
		r.aov_state = ctl.state;
		return r;
	endfunction

	function automatic in_item_t mk(logic [1:0] f, int cable, int pdo, int vout, int phm,
			int freq, int cap);
		in_item_t it;
		it.func = f;
		it.cable_class = 2'(cable);
		it.pdo_power_ok = 1'(pdo);
		it.measured_vout_mv = 14'(vout);
		it.power_hold = 1'(phm);
		it.op_freq = 10'(freq);
		it.capacity_permille = 10'(cap);
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_run || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_freq();
		int r, f;
		r = $urandom_range(0, 9);
		if (r < 4)
			f = int'(cfg_now.low_freq_threshold) + int'($urandom_range(0, 4)) - 2;
		else if (r < 8)
			f = int'(cfg_now.high_freq_threshold) + int'($urandom_range(0, 4)) - 2;
		else
			f = $urandom_range(0, 1023);
		if (f < 0)
			f = 0;
		if (f > 1023)
			f = 1023;
		return f;
	endfunction

	function automatic int pick_cap();
		return ($urandom_range(0, 1) != 0) ? $urandom_range(960, 980) : $urandom_range(0, 1023);
	endfunction

	function automatic in_item_t random_event();
		return mk(2'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 1),
			$urandom_range(0, 16383), $urandom_range(0, 1), $urandom_range(0, 1023),
			$urandom_range(0, 1023));
	endfunction

	task automatic queue_event(in_item_t it);
		event_queue.push_back(it);
		n_queued++;
	endtask

	// one plug-in: query, preset ramp, monitor steps with power-hold spells, sometimes a teardown
	task automatic add_session();
		int v, r, hold_left, start_mv;
		start_mv = cfg_now.start_voltage_mv;
		hold_left = 0;
		r = $urandom_range(0, 9);
		queue_event(mk(FUNC_QUERY, (r < 6) ? CABLE_PPS : CABLE_NOCHG,
			(r == 9) ? $urandom_range(0, 1) : 1, $urandom_range(0, 16383),
			$urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1023)));
		v = start_mv - 500 * int'($urandom_range(0, 4));
		if ($urandom_range(0, 3) == 0)
			v -= $urandom_range(1, 499);
		if (v < 0)
			v = 0;
		repeat ($urandom_range(3, 16)) begin
			if ($urandom_range(0, 12) == 0)
				queue_event(mk(FUNC_QUERY, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 16383), 0, $urandom_range(0, 1023), pick_cap()));
			if (v < start_mv) begin
				queue_event(mk(FUNC_MONITOR, $urandom_range(0, 3), $urandom_range(0, 1), v,
					$urandom_range(0, 1), pick_freq(), pick_cap()));
				v += 500;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 7)
					v = int'(VMIN_MV) + 500 * int'($urandom_range(0, 5));
				else if (r < 9)
					v = $urandom_range(4500, 8000);
				else
					v = $urandom_range(0, 16383);
				if (hold_left > 0)
					hold_left--;
				else if ($urandom_range(0, 7) == 0)
					hold_left = $urandom_range(1, 4);
				queue_event(mk(FUNC_MONITOR, $urandom_range(0, 3), $urandom_range(0, 1), v,
					(hold_left > 0) ? 1 : 0, pick_freq(), pick_cap()));
			end
		end
		r = $urandom_range(0, 9);
		if (r < 4)
			queue_event(mk(FUNC_RESET, $urandom_range(0, 3), $urandom_range(0, 1),
				$urandom_range(0, 16383), $urandom_range(0, 1), $urandom_range(0, 1023),
				$urandom_range(0, 1023)));
		else if (r < 6)
			queue_event(mk(FUNC_QUERY, (r == 4) ? CABLE_WIRED : CABLE_UNKNOWN,
				$urandom_range(0, 1), $urandom_range(0, 16383), 0, 0, 0));
	endtask

	task automatic fill_random(int count);
		int first;
		first = n_queued;
		while (n_queued - first < count) begin
			if ($urandom_range(0, 99) < 85)
				add_session();
			else
				queue_event(random_event());
		end
	endtask

	task automatic wait_idle();
		while (event_queue.size() != 0 || n_in_acc != n_driven || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_AOV_ENABLE:     cfg_now.aov_enable = val[0];
		REG_START_VOLTAGE:  cfg_now.start_voltage_mv = val[12:0];
		REG_LOW_FREQ:       cfg_now.low_freq_threshold = val[9:0];
		REG_HIGH_FREQ:      cfg_now.high_freq_threshold = val[9:0];
		REG_STEP_DELAY:     cfg_now.step_delay_ms = val[15:0];
		REG_HOLD_CURRENT:   cfg_now.hold_current_ma = val[11:0];
		REG_HOLD_CURR_FULL: cfg_now.hold_current_full_ma = val[11:0];
		REG_GEAR_CURRENT:   cfg_now.gear_current_ma = val[11:0];
		default: ;
		endcase
	endtask

	task automatic program_phase(int phase);
		cfg_t c;
		case (phase)
		1: c = '{1'b0, 13'd5000, 10'd0, 10'd0, 16'd0, 12'd0, 12'd0, 12'd0};
		2: c = '{1'b1, 13'd7500, 10'd1023, 10'd1023, 16'hffff, 12'd4095, 12'd4095, 12'd4095};
		default: begin
			c.aov_enable = ($urandom_range(0, 5) != 0);
			c.start_voltage_mv = ($urandom_range(0, 1) != 0) ?
				13'(5000 + 500 * $urandom_range(0, 5)) : 13'($urandom_range(5000, 7500));
			c.low_freq_threshold = 10'($urandom_range(0, 1023));
			c.high_freq_threshold = ($urandom_range(0, 1) != 0) ?
				10'($urandom_range(0, 1023)) :
				10'(c.low_freq_threshold + 10'($urandom_range(0, 40)));
			c.step_delay_ms = 16'($urandom);
			c.hold_current_ma = 12'($urandom);
			c.hold_current_full_ma = 12'($urandom);
			c.gear_current_ma = ($urandom_range(0, 1) != 0) ? 12'd0 : 12'($urandom);
		end
		endcase
		write_reg(REG_AOV_ENABLE, {31'd0, c.aov_enable});
		write_reg(REG_START_VOLTAGE, {19'd0, c.start_voltage_mv});
		write_reg(REG_LOW_FREQ, {22'd0, c.low_freq_threshold});
		write_reg(REG_HIGH_FREQ, {22'd0, c.high_freq_threshold});
		write_reg(REG_STEP_DELAY, {16'd0, c.step_delay_ms});
		write_reg(REG_HOLD_CURRENT, {20'd0, c.hold_current_ma});
		write_reg(REG_HOLD_CURR_FULL, {20'd0, c.hold_current_full_ma});
		write_reg(REG_GEAR_CURRENT, {20'd0, c.gear_current_ma});
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
			failed = 1'b1;
		end
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && n_in_acc != n_driven)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (event_queue.size() != 0) begin
				ev = event_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_DATA_W-38){1'b0}}, ev.capacity_permille, ev.op_freq,
					ev.power_hold, ev.measured_vout_mv, ev.pdo_power_ok, ev.cable_class};
				s_tuser <= ev.func;
				n_driven++;
				gap_left = pick_gap();
				if ($urandom_range(0, 99) == 0)
					quiet_run = !quiet_run;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// predict on each input beat, check each result beat
	always @(posedge clk) begin
		if (arst_n) begin
			active = 1'b0;
			if (s_tvalid && s_tready) begin
				seen.func = s_tuser;
				seen.cable_class = s_tdata[1:0];
				seen.pdo_power_ok = s_tdata[2];
				seen.measured_vout_mv = s_tdata[16:3];
				seen.power_hold = s_tdata[17];
				seen.op_freq = s_tdata[27:18];
				seen.capacity_permille = s_tdata[37:28];
				expected_results.push_back(step_controller(seen));
				n_in_acc++;
				active = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				active = 1'b1;
				got.enabled = m_tdata[0];
				got.aov_state = m_tdata[3:1];
				got.vout_set = m_tdata[4];
				got.vout_cmd_mv = m_tdata[18:5];
				got.icl_action = m_tdata[20:19];
				got.icl_cmd_ma = m_tdata[32:21];
				got.uno_iout_set = m_tdata[33];
				got.delay_set = m_tdata[34];
				got.delay_ms = m_tdata[51:35];
				got.vote_refresh = m_tdata[52];
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected, expected nothing, actual %h",
						$time, m_tdata);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					check_field("enabled", 32'(want.enabled), 32'(got.enabled));
					check_field("aov_state", 32'(want.aov_state), 32'(got.aov_state));
					check_field("vout_set", 32'(want.vout_set), 32'(got.vout_set));
					check_field("vout_cmd_mv", 32'(want.vout_cmd_mv), 32'(got.vout_cmd_mv));
					check_field("icl_action", 32'(want.icl_action), 32'(got.icl_action));
					check_field("icl_cmd_ma", 32'(want.icl_cmd_ma), 32'(got.icl_cmd_ma));
					check_field("uno_iout_set", 32'(want.uno_iout_set), 32'(got.uno_iout_set));
					check_field("delay_set", 32'(want.delay_set), 32'(got.delay_set));
					check_field("delay_ms", 32'(want.delay_ms), 32'(got.delay_ms));
					check_field("vote_refresh", 32'(want.vote_refresh), 32'(got.vote_refresh));
				end
			end
			if (psel)
				active = 1'b1;
			if (active)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on reset register values
		queue_event(mk(FUNC_NOOP, 0, 0, 0, 0, 0, 0));
		queue_event(mk(FUNC_QUERY, CABLE_PPS, 0, 16383, 1, 1023, 1023));
		queue_event(mk(FUNC_QUERY, CABLE_WIRED, 1, 0, 0, 0, 0));
		queue_event(mk(FUNC_QUERY, CABLE_PPS, 1, 0, 0, 0, 0));
		queue_event(mk(FUNC_QUERY, CABLE_NOCHG, 0, 0, 0, 0, 0));
		queue_event(mk(FUNC_MONITOR, 0, 0, 4000, 0, 140, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 4500, 0, 140, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5000, 0, 140, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5500, 0, 100, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 7500, 0, 0, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5000, 0, 1023, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 6000, 0, 1023, 500));
		queue_event(mk(FUNC_QUERY, CABLE_NOCHG, 1, 0, 0, 0, 0));
		queue_event(mk(FUNC_QUERY, CABLE_PPS, 0, 0, 0, 0, 0));
		queue_event(mk(FUNC_MONITOR, 0, 0, 6000, 0, 140, 500));
		queue_event(mk(FUNC_MONITOR, 0, 0, 6000, 1, 140, 969));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5000, 1, 140, 970));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5000, 1, 140, 1023));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5000, 0, 140, 0));
		queue_event(mk(FUNC_QUERY, CABLE_UNKNOWN, 1, 0, 0, 0, 0));
		queue_event(mk(FUNC_MONITOR, 3, 1, 16383, 0, 0, 1023));
		queue_event(mk(FUNC_QUERY, CABLE_WIRED, 0, 0, 0, 0, 0));
		queue_event(mk(FUNC_MONITOR, 0, 0, 5500, 0, 500, 0));
		queue_event(mk(FUNC_RESET, 0, 0, 0, 0, 0, 0));
		queue_event(mk(FUNC_NOOP, 3, 1, 16383, 1, 1023, 1023));
		fill_random(BEATS_PER_PHASE);

		for (phase = 1; phase <= 6; phase++) begin
			wait_idle();
			program_phase(phase);
			fill_random(BEATS_PER_PHASE);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
